[hdl/iidl_pkg.sv]
// shared types and codes for the indexed insert/delete list
package iidl_pkg;

   // request function codes
   typedef enum logic [2:0] {
      FUNC_GET     = 3'd0,
      FUNC_APPEND  = 3'd1,
      FUNC_PREPEND = 3'd2,
      FUNC_INSERT  = 3'd3,
      FUNC_REPLACE = 3'd4,
      FUNC_DELETE  = 3'd5
   } func_type;

   // result status codes
   typedef enum logic [1:0] {
      STATUS_OK   = 2'd0,
      STATUS_ZERO = 2'd1,
      STATUS_OOB  = 2'd2,
      STATUS_FULL = 2'd3
   } status_type;

   // operation broadcast to every cell of the row
   typedef enum logic [1:0] {
      CELL_HOLD    = 2'd0,
      CELL_INSERT  = 2'd1,
      CELL_DELETE  = 2'd2,
      CELL_REPLACE = 2'd3
   } cell_op_type;

   // decoded control for one transaction
   typedef struct packed {
      cell_op_type kind;
      logic        read_en;
      status_type  status;
   } ctl_type;

endpackage

[hdl/indexed_insert_delete_list.sv]
// top level: ordered word list with indexed insert, replace and delete
//
// Requests enter on the req_ channel (req_func, req_position, req_item_in)
// under valid/ready. Each transaction produces exactly one result on the
// rsp_ channel: rsp_status, rsp_item_out (item read by get or removed by
// delete, else zero) and rsp_count_now (item count after the request).
// The list is a row of CAPACITY cells; insert and delete shift every
// affected cell in the same cycle, so the block sustains one transaction
// per cycle while the receiver keeps up. An accepted request's result
// is written to the output register in the cycle after acceptance.
// The output register takes a new result whenever it is empty or being
// drained; while the receiver stalls, req_ready stays low and the held
// result is kept unchanged.
// The csr_ channel writes capacity_limit (always ready); write it only while
// no transaction is in flight.
// Reset (synchronous, active high) empties the list, sets capacity_limit to
// CAPACITY and drops rsp_valid. Cell contents are not cleared; only entries
// below the count are ever read.
module indexed_insert_delete_list #(
   parameter int CAPACITY   = 16,
   parameter int ITEM_WIDTH = 32,
   parameter int CNT_W      = $clog2(CAPACITY + 1)
) (
   input  logic                   clock,
   input  logic                   reset,
   // request channel
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [2:0]             req_func,
   input  logic [CNT_W-1:0]       req_position,
   input  logic [ITEM_WIDTH-1:0]  req_item_in,
   // result channel
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [1:0]             rsp_status,
   output logic [ITEM_WIDTH-1:0]  rsp_item_out,
   output logic [CNT_W-1:0]       rsp_count_now,
   // configuration channel
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CNT_W-1:0]       csr_capacity_limit
);
   import iidl_pkg::*;

   logic [CNT_W-1:0]      count_ff, count_in;
   logic [CNT_W-1:0]      limit_ff;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [1:0]            rsp_status_ff;
   logic [ITEM_WIDTH-1:0] rsp_item_ff;
   logic [CNT_W-1:0]      rsp_count_ff;

   logic                  accept;
   ctl_type               ctl;
   cell_op_type           cell_op;
   logic [CNT_W-1:0]      op_pos;
   logic [CNT_W-1:0]      count_next;
   logic [ITEM_WIDTH-1:0] read_item;

   logic [ITEM_WIDTH-1:0] cell_item [CAPACITY];
   logic [ITEM_WIDTH-1:0] cell_sel  [CAPACITY];

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign csr_ready = 1'b1;

   // request decode
   iidl_ctrl #(
      .CAPACITY  (CAPACITY),
      .CNT_W     (CNT_W),
      .ITEM_WIDTH(ITEM_WIDTH)
   ) u_ctrl (
      .func      (req_func),
      .position  (req_position),
      .item_in   (req_item_in),
      .count     (count_ff),
      .limit     (limit_ff),
      .ctl       (ctl),
      .op_pos    (op_pos),
      .count_next(count_next)
   );

   assign cell_op = accept ? ctl.kind : CELL_HOLD;

   // row of cells
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic [ITEM_WIDTH-1:0] left_item;
      logic [ITEM_WIDTH-1:0] right_item;
      if (i == 0) begin : g_first
         assign left_item = '0;
      end else begin : g_mid_l
         assign left_item = cell_item[i-1];
      end
      if (i == CAPACITY - 1) begin : g_last
         assign right_item = '0;
      end else begin : g_mid_r
         assign right_item = cell_item[i+1];
      end
      iidl_cell #(
         .IDX       (i),
         .CNT_W     (CNT_W),
         .ITEM_WIDTH(ITEM_WIDTH)
      ) u_cell (
         .clock     (clock),
         .op        (cell_op),
         .pos       (op_pos),
         .count     (count_ff),
         .new_item  (req_item_in),
         .left_item (left_item),
         .right_item(right_item),
         .item      (cell_item[i]),
         .sel_item  (cell_sel[i])
      );
   end

   // read port: only the addressed cell drives a nonzero word
   always_comb begin
      read_item = '0;
      for (int k = 0; k < CAPACITY; k++) begin
         read_item = read_item | cell_sel[k];
      end
   end

   // count and output valid
   always_comb begin
      count_in     = accept ? count_next : count_ff;
      rsp_valid_in = accept ? 1'b1 : (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         limit_ff     <= CNT_W'(CAPACITY);
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            limit_ff <= csr_capacity_limit;
         end
      end
   end

   // result payload register
   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_status_ff <= ctl.status;
         rsp_item_ff   <= ctl.read_en ? read_item : '0;
         rsp_count_ff  <= count_next;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_item_out  = rsp_item_ff;
   assign rsp_count_now = rsp_count_ff;

endmodule

[hdl/iidl_cell.sv]
// one storage cell of the list row, shifting with its neighbors
module iidl_cell #(
   parameter int IDX        = 0,
   parameter int CNT_W      = 5,
   parameter int ITEM_WIDTH = 32
) (
   input  logic                  clock,
   input  iidl_pkg::cell_op_type op,
   input  logic [CNT_W-1:0]      pos,
   input  logic [CNT_W-1:0]      count,
   input  logic [ITEM_WIDTH-1:0] new_item,
   input  logic [ITEM_WIDTH-1:0] left_item,
   input  logic [ITEM_WIDTH-1:0] right_item,
   output logic [ITEM_WIDTH-1:0] item,
   output logic [ITEM_WIDTH-1:0] sel_item
);
   import iidl_pkg::*;

   localparam logic [CNT_W:0] MY_IDX  = (CNT_W+1)'(IDX);
   localparam logic [CNT_W:0] NXT_IDX = (CNT_W+1)'(IDX + 1);

   logic [ITEM_WIDTH-1:0] data_ff;
   logic [ITEM_WIDTH-1:0] data_in;
   logic [CNT_W:0]        pos_x;
   logic [CNT_W:0]        count_x;
   logic                  at_pos;

   assign pos_x   = {1'b0, pos};
   assign count_x = {1'b0, count};
   assign at_pos  = (MY_IDX == pos_x);

   // next value from the broadcast operation
   always_comb begin
      data_in = data_ff;
      case (op)
         CELL_INSERT: begin
            if (at_pos) begin
               data_in = new_item;
            end else if (MY_IDX > pos_x && MY_IDX <= count_x) begin
               data_in = left_item;
            end
         end
         CELL_DELETE: begin
            if (MY_IDX >= pos_x && NXT_IDX < count_x) begin
               data_in = right_item;
            end
         end
         CELL_REPLACE: begin
            if (at_pos) begin
               data_in = new_item;
            end
         end
         default: begin
            data_in = data_ff;
         end
      endcase
   end

   // entry storage
   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign item     = data_ff;
   assign sel_item = at_pos ? data_ff : '0;

endmodule

[hdl/iidl_ctrl.sv]
// request decode: status, cell operation and new count
module iidl_ctrl #(
   parameter int CAPACITY   = 16,
   parameter int CNT_W      = 5,
   parameter int ITEM_WIDTH = 32
) (
   input  logic [2:0]            func,
   input  logic [CNT_W-1:0]      position,
   input  logic [ITEM_WIDTH-1:0] item_in,
   input  logic [CNT_W-1:0]      count,
   input  logic [CNT_W-1:0]      limit,
   output iidl_pkg::ctl_type     ctl,
   output logic [CNT_W-1:0]      op_pos,
   output logic [CNT_W-1:0]      count_next
);
   import iidl_pkg::*;

   localparam logic [CNT_W-1:0] CAP_C = CNT_W'(CAPACITY);
   localparam logic [CNT_W-1:0] ONE_C = CNT_W'(1);

   logic [CNT_W-1:0] lim_eff;
   logic             full;
   logic             zero_item;

   // limit clamped to one .. capacity
   always_comb begin
      if (limit == '0) begin
         lim_eff = ONE_C;
      end else if (limit > CAP_C) begin
         lim_eff = CAP_C;
      end else begin
         lim_eff = limit;
      end
   end

   assign full      = (count >= lim_eff) || (count >= CAP_C);
   assign zero_item = (item_in == '0);

   // status and operation per function
   always_comb begin
      ctl.kind    = CELL_HOLD;
      ctl.read_en = 1'b0;
      ctl.status  = STATUS_OK;
      op_pos      = position;
      count_next  = count;
      case (func)
         FUNC_GET: begin
            if (position >= count) begin
               ctl.status = STATUS_OOB;
            end else begin
               ctl.read_en = 1'b1;
            end
         end
         FUNC_APPEND, FUNC_PREPEND: begin
            op_pos = (func == FUNC_APPEND) ? count : '0;
            if (zero_item) begin
               ctl.status = STATUS_ZERO;
            end else if (full) begin
               ctl.status = STATUS_FULL;
            end else begin
               ctl.kind   = CELL_INSERT;
               count_next = count + ONE_C;
            end
         end
         FUNC_INSERT: begin
            if (zero_item) begin
               ctl.status = STATUS_ZERO;
            end else if (position > count) begin
               ctl.status = STATUS_OOB;
            end else if (full) begin
               ctl.status = STATUS_FULL;
            end else begin
               ctl.kind   = CELL_INSERT;
               count_next = count + ONE_C;
            end
         end
         FUNC_REPLACE: begin
            if (zero_item) begin
               ctl.status = STATUS_ZERO;
            end else if (position >= count) begin
               ctl.status = STATUS_OOB;
            end else begin
               ctl.kind = CELL_REPLACE;
            end
         end
         FUNC_DELETE: begin
            if (position >= count) begin
               ctl.status = STATUS_OOB;
            end else begin
               ctl.kind    = CELL_DELETE;
               ctl.read_en = 1'b1;
               count_next  = count - ONE_C;
            end
         end
         default: begin
            ctl.status = STATUS_OOB;
         end
      endcase
   end

endmodule

[hdl/iidl_checker.sv]
// port-level checks for the indexed insert/delete list, bound to the top level
module iidl_checker #(
   parameter int CAPACITY   = 16,
   parameter int ITEM_WIDTH = 32,
   parameter int CNT_W      = $clog2(CAPACITY + 1)
) (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_ready,
   input logic                  rsp_valid,
   input logic                  rsp_ready,
   input logic [1:0]            rsp_status,
   input logic [ITEM_WIDTH-1:0] rsp_item_out,
   input logic [CNT_W-1:0]      rsp_count_now
);
   import iidl_pkg::*;

   // every accepted request shows a result on the next cycle
   a_req_to_rsp: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> rsp_valid)
      else $error("no result after accepted request");

   // a stalled result holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
         && $stable(rsp_item_out) && $stable(rsp_count_now))
      else $error("stalled result changed");

   // failed requests return no item
   a_fail_no_item: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != STATUS_OK |-> rsp_item_out == '0)
      else $error("item returned on failed request");

   // full is only reported with at least one item held, never above capacity
   a_full_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STATUS_FULL |-> rsp_count_now != '0
         && rsp_count_now <= CNT_W'(CAPACITY))
      else $error("full reported with bad count");

endmodule

bind indexed_insert_delete_list iidl_checker #(
   .CAPACITY  (CAPACITY),
   .ITEM_WIDTH(ITEM_WIDTH),
   .CNT_W     (CNT_W)
) u_iidl_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_valid),
   .req_ready    (req_ready),
   .rsp_valid    (rsp_valid),
   .rsp_ready    (rsp_ready),
   .rsp_status   (rsp_status),
   .rsp_item_out (rsp_item_out),
   .rsp_count_now(rsp_count_now)
);

[tb/tb_indexed_insert_delete_list.sv]
// testbench for the indexed insert/delete list: directed and random traffic against a local list predictor
`timescale 1ns / 100ps

module tb_indexed_insert_delete_list;
   import iidl_pkg::*;

   localparam int CAP         = 16;
   localparam int ITEM_W      = 32;
   localparam int CNT_W       = 5;
   localparam int CYCLE_LIMIT = 1000000;
   localparam int PHASE_ITEMS = 235;
   localparam int HOLD_CYCLES = 300;

   // function codes the block does not define
   localparam logic [2:0] FUNC_UNUSED_A = 3'd6;
   localparam logic [2:0] FUNC_UNUSED_B = 3'd7;

   // two copies of the list: one follows accepted transactions, one plans stimulus
   localparam int CHECK_VIEW = 0;
   localparam int PLAN_VIEW  = 1;

   typedef struct packed {
      logic [2:0]        func;
      logic [CNT_W-1:0]  position;
      logic [ITEM_W-1:0] item;
   } request_type;

   typedef struct packed {
      status_type        status;
      logic [ITEM_W-1:0] item_out;
      logic [CNT_W-1:0]  count_now;
   } reply_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic              req_valid = 1'b0;
   logic              req_ready;
   logic [2:0]        req_func = '0;
   logic [CNT_W-1:0]  req_position = '0;
   logic [ITEM_W-1:0] req_item_in = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   logic [1:0]        rsp_status;
   logic [ITEM_W-1:0] rsp_item_out;
   logic [CNT_W-1:0]  rsp_count_now;
   logic              csr_valid = 1'b0;
   logic              csr_ready;
   logic [CNT_W-1:0]  csr_capacity_limit = '0;

   request_type pending_requests[$];
   reply_type   expected_replies[$];

   logic [ITEM_W-1:0] model_cells [2][CAP];
   int unsigned       model_count [2];
   logic [CNT_W-1:0]  model_limit [2];

   int unsigned outstanding = 0;
   int unsigned error_count = 0;
   int unsigned replies_seen = 0;
   int unsigned cycle_count = 0;
   int unsigned send_gap = 0;
   int unsigned send_calm = 0;
   int unsigned recv_gap = 0;
   int unsigned recv_calm = 0;
   int unsigned hold_left = 0;
   bit          growing = 1'b1;

   logic [CNT_W-1:0] phase_limits [8];

   indexed_insert_delete_list #(
      .CAPACITY   (CAP),
      .ITEM_WIDTH (ITEM_W)
   ) dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_func           (req_func),
      .req_position       (req_position),
      .req_item_in        (req_item_in),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_status         (rsp_status),
      .rsp_item_out       (rsp_item_out),
      .rsp_count_now      (rsp_count_now),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_capacity_limit (csr_capacity_limit)
   );

   always #2 clock = ~clock;

   // zero acts as one, anything above the store size acts as the store size
   function automatic int unsigned limit_in_force(input logic [CNT_W-1:0] lim);
      if (lim == '0) return 1;
      if (lim > CAP) return CAP;
      return lim;
   endfunction

   // expected reply for one request; updates the chosen copy of the list
   function automatic reply_type predict_list_op(input int v, input request_type r);
      reply_type   e;
      bit          full;
      bit          place;
      int unsigned at;
      int unsigned i;
      e.status   = STATUS_OK;
      e.item_out = '0;
      place      = 1'b0;
      at         = 0;
      full       = model_count[v] >= limit_in_force(model_limit[v]);
      case (r.func)
         FUNC_GET: begin
            if (r.position >= model_count[v]) e.status = STATUS_OOB;
            else e.item_out = model_cells[v][r.position];
         end
         FUNC_APPEND, FUNC_PREPEND: begin
            if (r.item == '0) e.status = STATUS_ZERO;
            else if (full) e.status = STATUS_FULL;
            else begin
               place = 1'b1;
               at    = (r.func == FUNC_APPEND) ? model_count[v] : 0;
            end
         end
         FUNC_INSERT: begin
            if (r.item == '0) e.status = STATUS_ZERO;
            else if (r.position > model_count[v]) e.status = STATUS_OOB;
            else if (full) e.status = STATUS_FULL;
            else begin
               place = 1'b1;
               at    = r.position;
            end
         end
         FUNC_REPLACE: begin
            if (r.item == '0) e.status = STATUS_ZERO;
            else if (r.position >= model_count[v]) e.status = STATUS_OOB;
            else model_cells[v][r.position] = r.item;
         end
         FUNC_DELETE: begin
            if (r.position >= model_count[v]) e.status = STATUS_OOB;
            else begin
               e.item_out = model_cells[v][r.position];
               for (i = r.position; i + 1 < model_count[v]; i++)
                  model_cells[v][i] = model_cells[v][i + 1];
               model_count[v]--;
            end
         end
         default: e.status = STATUS_OOB;
      endcase
      // open a gap and shift later entries up
      if (place) begin
         for (i = model_count[v]; i > at; i--)
            model_cells[v][i] = model_cells[v][i - 1];
         model_cells[v][at] = r.item;
         model_count[v]++;
      end
      e.count_now = CNT_W'(model_count[v]);
      return e;
   endfunction

   // idle length: mostly short, a few long, with occasional calm stretches
   function automatic int unsigned draw_gap(inout int unsigned calm);
      int unsigned roll;
      if (calm > 0) begin
         calm--;
         return 0;
      end
      if ($urandom_range(0, 199) == 0) begin
         calm = $urandom_range(40, 120);
         return 0;
      end
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      if (roll < 85) return $urandom_range(1, 3);
      if (roll < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // random request shaped by the planned list: grow toward full, then drain
   function automatic request_type random_request();
      request_type r;
      int unsigned roll;
      int unsigned cnt;
      cnt = model_count[PLAN_VIEW];
      if (cnt >= limit_in_force(model_limit[PLAN_VIEW])) growing = 1'b0;
      else if (cnt == 0) growing = 1'b1;
      roll = $urandom_range(0, 99);
      if (roll < 2) r.func = FUNC_UNUSED_A;
      else if (roll < 4) r.func = FUNC_UNUSED_B;
      else if (roll < 18) r.func = FUNC_GET;
      else if (roll < 28) r.func = FUNC_REPLACE;
      else if (roll < (growing ? 80 : 48)) begin
         case ($urandom_range(0, 2))
            0: r.func = FUNC_APPEND;
            1: r.func = FUNC_PREPEND;
            default: r.func = FUNC_INSERT;
         endcase
      end else r.func = FUNC_DELETE;
      // mostly valid positions, some anywhere in the field
      if ($urandom_range(0, 9) == 0) r.position = CNT_W'($urandom_range(0, 31));
      else if (r.func == FUNC_INSERT) r.position = CNT_W'($urandom_range(0, cnt));
      else if (cnt > 0) r.position = CNT_W'($urandom_range(0, cnt - 1));
      else r.position = '0;
      roll = $urandom_range(0, 99);
      if (roll < 3) r.item = '0;
      else if (roll < 6) r.item = '1;
      else if (roll < 8) r.item = 1;
      else r.item = $urandom;
      return r;
   endfunction

   task automatic queue_request(input logic [2:0] func, input logic [CNT_W-1:0] pos,
                                input logic [ITEM_W-1:0] item);
      request_type r;
      r = {func, pos, item};
      void'(predict_list_op(PLAN_VIEW, r));
      outstanding++;
      pending_requests.push_back(r);
   endtask

   task automatic wait_drained();
      while (outstanding != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic write_limit(input logic [CNT_W-1:0] value);
      csr_valid          <= 1'b1;
      csr_capacity_limit <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      model_limit[CHECK_VIEW] = value;
      model_limit[PLAN_VIEW]  = value;
      csr_valid <= 1'b0;
   endtask

   // request driver: predicts on acceptance, then loads the next pending item
   always @(posedge clock) begin
      request_type next;
      if (reset) begin
         req_valid <= 1'b0;
         send_gap = 0;
      end else begin
         if (req_valid && req_ready)
            expected_replies.push_back(predict_list_op(CHECK_VIEW,
               {req_func, req_position, req_item_in}));
         if (!req_valid || req_ready) begin
            if (send_gap > 0) begin
               send_gap--;
               req_valid <= 1'b0;
            end else if (pending_requests.size() > 0) begin
               next = pending_requests.pop_front();
               req_valid    <= 1'b1;
               req_func     <= next.func;
               req_position <= next.position;
               req_item_in  <= next.item;
               send_gap = draw_gap(send_calm);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // reply monitor and receiver back-pressure
   always @(posedge clock) begin
      reply_type e;
      if (reset) begin
         rsp_ready <= 1'b0;
         recv_gap  = 0;
         hold_left = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_replies.size() == 0) begin
               $error("reply with no transaction outstanding: status %0d item %h count %0d",
                      rsp_status, rsp_item_out, rsp_count_now);
               error_count++;
            end else begin
               e = expected_replies.pop_front();
               if (rsp_status !== e.status) begin
                  $error("status: expected %0d, actual %0d", e.status, rsp_status);
                  error_count++;
               end
               if (rsp_item_out !== e.item_out) begin
                  $error("item_out: expected %h, actual %h", e.item_out, rsp_item_out);
                  error_count++;
               end
               if (rsp_count_now !== e.count_now) begin
                  $error("count_now: expected %0d, actual %0d", e.count_now, rsp_count_now);
                  error_count++;
               end
               outstanding--;
            end
            replies_seen++;
            // long hold-off so the block fills and stalls its input
            if (replies_seen == 300 || replies_seen == 1200) hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (recv_gap > 0) begin
            recv_gap--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
            recv_gap = draw_gap(recv_calm);
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // sequence: reset, directed checks, then random phases under changing limits
   initial begin
      for (int v = 0; v < 2; v++) begin
         model_count[v] = 0;
         model_limit[v] = CNT_W'(CAP);
         for (int c = 0; c < CAP; c++) model_cells[v][c] = '0;
      end
      phase_limits = '{5'd16, 5'd3, 5'd31, 5'd1, 5'd0, 5'd17, 5'd9, 5'd16};

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // empty list, zero refusal, both ends, insert at and past the end
      queue_request(FUNC_GET, 5'd0, 32'h1234_5678);
      queue_request(FUNC_DELETE, 5'd0, '0);
      queue_request(FUNC_APPEND, 5'd0, '0);
      queue_request(FUNC_APPEND, 5'd0, 32'hFFFF_FFFF);
      queue_request(FUNC_PREPEND, 5'd31, 32'h0000_0001);
      queue_request(FUNC_INSERT, 5'd1, 32'h8000_0000);
      queue_request(FUNC_INSERT, 5'd3, 32'h5555_5555);
      queue_request(FUNC_INSERT, 5'd5, 32'h0F0F_0F0F);
      queue_request(FUNC_INSERT, 5'd31, '0);
      // replace in and out of range, reads, middle and last delete
      queue_request(FUNC_REPLACE, 5'd0, 32'hAAAA_AAAA);
      queue_request(FUNC_REPLACE, 5'd4, 32'h7FFF_FFFF);
      queue_request(FUNC_REPLACE, 5'd2, '0);
      queue_request(FUNC_GET, 5'd3, '0);
      queue_request(FUNC_GET, 5'd31, '1);
      queue_request(FUNC_DELETE, 5'd1, '1);
      queue_request(FUNC_DELETE, 5'd2, '0);
      // undefined function codes, then empty the list and read out of range
      queue_request(FUNC_UNUSED_A, 5'd0, 32'h0000_0001);
      queue_request(FUNC_UNUSED_B, 5'd31, '1);
      queue_request(FUNC_DELETE, 5'd0, '0);
      queue_request(FUNC_GET, 5'd0, '0);
      queue_request(FUNC_DELETE, 5'd0, '0);
      queue_request(FUNC_GET, 5'd16, '0);
      wait_drained();

      for (int p = 0; p < 8; p++) begin
         write_limit(phase_limits[p]);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            request_type r;
            r = random_request();
            queue_request(r.func, r.position, r.item);
         end
         wait_drained();
      end

      if (error_count == 0 && expected_replies.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

[indexed_insert_delete_list.f]
hdl/iidl_pkg.sv
hdl/iidl_cell.sv
hdl/iidl_ctrl.sv
hdl/indexed_insert_delete_list.sv
hdl/iidl_checker.sv
tb/tb_indexed_insert_delete_list.sv
